// File: rtl/core/kmcfp_pkg.sv
// ----------------------------------------------------------------------------
// kmcfp_pkg
// shared types and constants of the key/mouse command frame parser
// ----------------------------------------------------------------------------
package kmcfp_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 8;   // default payload store depth
    localparam int unsigned REPORT_BYTES    = 8;   // payload bytes carried per job
    localparam int unsigned QUEUE_DEPTH     = 2;

    localparam logic [7:0] HDR1         = 8'h57;
    localparam logic [7:0] HDR2         = 8'hAB;
    localparam logic [7:0] CMD_KEYBOARD = 8'h02;
    localparam logic [7:0] CMD_MOUSE    = 8'h05;
    localparam logic [7:0] ACK_LEN      = 8'h01;
    localparam logic [7:0] ACK_STATUS   = 8'h00;
    // constant part of the acknowledgement sum
    localparam logic [7:0] ACK_SUM_BASE = HDR1 + HDR2 + ACK_LEN + ACK_STATUS;
    localparam logic [7:0] HDR_SUM      = HDR1 + HDR2;

    localparam logic [1:0] DEST_KEYBOARD = 2'd0;
    localparam logic [1:0] DEST_MOUSE    = 2'd1;
    localparam logic [1:0] DEST_ACK      = 2'd2;

    localparam logic [3:0] KBD_REPORT_LEN   = 4'd8;
    localparam logic [3:0] MOUSE_REPORT_LEN = 4'd4;
    localparam logic [3:0] ACK_PKT_LEN      = 4'd7;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_ADDR,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_SUM
    } phase_t;

    typedef enum logic [2:0] {
        ACK_B_HDR1,
        ACK_B_HDR2,
        ACK_B_ADDR,
        ACK_B_CMD,
        ACK_B_LEN,
        ACK_B_STATUS,
        ACK_B_SUM
    } ack_pos_t;

    // one accepted frame waiting to be emitted
    typedef struct packed {
        logic                        is_mouse;
        logic [7:0]                  address;
        logic [7:0]                  command;
        logic [REPORT_BYTES-1:0][7:0] data;   // already zeroed past the length
    } job_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

endpackage

// File: rtl/core/kmcfp_front.sv
// ----------------------------------------------------------------------------
// kmcfp_front
// frame hunter and field capture, pushes good frames as jobs
// ----------------------------------------------------------------------------
module kmcfp_front #(
    parameter int unsigned MAX_PAYLOAD = kmcfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               rx_byte,
    input  kmcfp_pkg::queue_status_t q_status,
    output logic                     push,
    output kmcfp_pkg::job_t          push_job
);

    localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned IW = $clog2(MAX_PAYLOAD);

    kmcfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]        addr_reg, addr_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [CW-1:0]     len_reg, len_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        store_reg [MAX_PAYLOAD];

    logic          take;
    logic          sum_ok;
    logic          known_cmd;
    logic          store_wr;
    logic          store_clr;
    logic [CW-1:0] count_inc;

    assign in_ready  = !((phase_reg == kmcfp_pkg::PH_SUM) && q_status.full);
    assign take      = in_valid && in_ready;
    assign sum_ok    = (rx_byte == sum_reg);
    assign known_cmd = (cmd_reg == kmcfp_pkg::CMD_KEYBOARD) || (cmd_reg == kmcfp_pkg::CMD_MOUSE);
    assign count_inc = count_reg + CW'(1);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            case (phase_reg)
                kmcfp_pkg::PH_HUNT1:
                begin
                    if (rx_byte == kmcfp_pkg::HDR1)
                        phase_next = kmcfp_pkg::PH_HUNT2;
                end
                kmcfp_pkg::PH_HUNT2:
                begin
                    phase_next = (rx_byte == kmcfp_pkg::HDR2) ? kmcfp_pkg::PH_ADDR
                                                               : kmcfp_pkg::PH_HUNT1;
                end
                kmcfp_pkg::PH_ADDR: phase_next = kmcfp_pkg::PH_CMD;
                kmcfp_pkg::PH_CMD:  phase_next = kmcfp_pkg::PH_LEN;
                kmcfp_pkg::PH_LEN:
                begin
                    if (rx_byte > 8'(MAX_PAYLOAD))
                        phase_next = kmcfp_pkg::PH_HUNT1;
                    else if (rx_byte == 8'd0)
                        phase_next = kmcfp_pkg::PH_SUM;
                    else
                        phase_next = kmcfp_pkg::PH_DATA;
                end
                kmcfp_pkg::PH_DATA:
                begin
                    if (count_inc >= len_reg)
                        phase_next = kmcfp_pkg::PH_SUM;
                end
                default: phase_next = kmcfp_pkg::PH_HUNT1;
            endcase
        end
    end

    // field capture and job output
    always_comb
    begin
        addr_next  = addr_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        store_wr   = 1'b0;
        store_clr  = 1'b0;
        push       = 1'b0;
        if (take)
        begin
            case (phase_reg)
                kmcfp_pkg::PH_HUNT2:
                begin
                    if (rx_byte == kmcfp_pkg::HDR2)
                    begin
                        store_clr  = 1'b1;
                        count_next = '0;
                        len_next   = '0;
                        sum_next   = kmcfp_pkg::HDR_SUM;
                    end
                end
                kmcfp_pkg::PH_ADDR:
                begin
                    addr_next = rx_byte;
                    sum_next  = sum_reg + rx_byte;
                end
                kmcfp_pkg::PH_CMD:
                begin
                    cmd_next = rx_byte;
                    sum_next = sum_reg + rx_byte;
                end
                kmcfp_pkg::PH_LEN:
                begin
                    // a length past the store aborts the frame, so truncation is harmless
                    len_next   = rx_byte[CW-1:0];
                    sum_next   = sum_reg + rx_byte;
                    count_next = '0;
                end
                kmcfp_pkg::PH_DATA:
                begin
                    store_wr   = (count_reg < CW'(MAX_PAYLOAD));
                    sum_next   = sum_reg + rx_byte;
                    count_next = count_inc;
                end
                kmcfp_pkg::PH_SUM:
                begin
                    push = sum_ok && known_cmd;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        push_job.is_mouse = (cmd_reg == kmcfp_pkg::CMD_MOUSE);
        push_job.address  = addr_reg;
        push_job.command  = cmd_reg;
        for (int i = 0; i < int'(kmcfp_pkg::REPORT_BYTES); i++)
        begin
            if ((i < int'(MAX_PAYLOAD)) && (CW'(i) < len_reg))
                push_job.data[i] = store_reg[i % MAX_PAYLOAD];
            else
                push_job.data[i] = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kmcfp_pkg::PH_HUNT1;
            addr_reg  <= '0;
            cmd_reg   <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(MAX_PAYLOAD); i++)
                store_reg[i] <= 8'h00;
        end
        else if (store_clr)
        begin
            for (int i = 0; i < int'(MAX_PAYLOAD); i++)
                store_reg[i] <= 8'h00;
        end
        else if (store_wr)
        begin
            store_reg[count_reg[IW-1:0]] <= rx_byte;
        end
    end

endmodule

// File: rtl/core/kmcfp_queue.sv
// ----------------------------------------------------------------------------
// kmcfp_queue
// short job queue between the frame parser and the byte emitter
// ----------------------------------------------------------------------------
module kmcfp_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  kmcfp_pkg::job_t          push_job,
    input  logic                     pop,
    output kmcfp_pkg::job_t          head_job,
    output kmcfp_pkg::queue_status_t status
);

    localparam int unsigned DEPTH = kmcfp_pkg::QUEUE_DEPTH;
    localparam int unsigned PW    = $clog2(DEPTH);

    kmcfp_pkg::job_t entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     fill_reg, fill_next;

    assign status.full      = (fill_reg == (PW+1)'(DEPTH));
    assign status.not_empty = (fill_reg != '0);
    assign head_job         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            fill_next = fill_reg + (PW+1)'(1);
        else if (pop && !push)
            fill_next = fill_reg - (PW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: rtl/core/kmcfp_back.sv
// ----------------------------------------------------------------------------
// kmcfp_back
// byte emitter: report bytes then the acknowledgement packet
// ----------------------------------------------------------------------------
module kmcfp_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  kmcfp_pkg::job_t          head_job,
    input  kmcfp_pkg::queue_status_t q_status,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               destination,
    output logic [7:0]               out_byte,
    output logic                     packet_end,
    output logic                     run_last
);

    kmcfp_pkg::job_t job_reg;
    logic            busy_reg, busy_next;
    logic [3:0]      idx_reg, idx_next;

    logic [3:0]      rpt_len;
    logic            in_report;
    logic [3:0]      ack_off;
    logic [2:0]      ack_pos;
    logic [2:0]      mouse_idx;
    logic            last_byte;
    logic            out_take;

    assign rpt_len   = job_reg.is_mouse ? kmcfp_pkg::MOUSE_REPORT_LEN
                                        : kmcfp_pkg::KBD_REPORT_LEN;
    assign in_report = (idx_reg < rpt_len);
    assign ack_off   = idx_reg - rpt_len;
    assign ack_pos   = ack_off[2:0];
    assign mouse_idx = idx_reg[2:0] + 3'd1;
    assign last_byte = (ack_off == kmcfp_pkg::ACK_PKT_LEN - 4'd1);
    assign out_take  = out_valid && out_ready;

    assign out_valid = busy_reg;
    assign run_last  = last_byte;
    assign pop       = q_status.not_empty && (!busy_reg || (out_take && last_byte));

    always_comb
    begin
        if (in_report)
        begin
            destination = job_reg.is_mouse ? kmcfp_pkg::DEST_MOUSE : kmcfp_pkg::DEST_KEYBOARD;
            packet_end  = (idx_reg == rpt_len - 4'd1);
            if (job_reg.is_mouse)
                out_byte = job_reg.data[mouse_idx];
            else if (idx_reg == 4'd1)
                out_byte = 8'h00;      // reserved byte of the keyboard report
            else
                out_byte = job_reg.data[idx_reg[2:0]];
        end
        else
        begin
            destination = kmcfp_pkg::DEST_ACK;
            packet_end  = last_byte;
            case (kmcfp_pkg::ack_pos_t'(ack_pos))
                kmcfp_pkg::ACK_B_HDR1:   out_byte = kmcfp_pkg::HDR1;
                kmcfp_pkg::ACK_B_HDR2:   out_byte = kmcfp_pkg::HDR2;
                kmcfp_pkg::ACK_B_ADDR:   out_byte = job_reg.address;
                kmcfp_pkg::ACK_B_CMD:    out_byte = job_reg.command;
                kmcfp_pkg::ACK_B_LEN:    out_byte = kmcfp_pkg::ACK_LEN;
                kmcfp_pkg::ACK_B_STATUS: out_byte = kmcfp_pkg::ACK_STATUS;
                default:
                    out_byte = job_reg.address + job_reg.command + kmcfp_pkg::ACK_SUM_BASE;
            endcase
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (out_take)
        begin
            if (last_byte)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head_job;
    end

endmodule

// File: rtl/core/key_mouse_command_frame_parser_core.sv
// ----------------------------------------------------------------------------
// key_mouse_command_frame_parser_core
// serial command frame parser emitting keyboard/mouse reports and acks
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | rx_byte[7:0]
//  out     | out_valid/ out_ready | destination[1:0], out_byte[7:0],
//          |                      | packet_end, run_last
//
//  one received byte is taken per cycle whenever in_ready is high
//  a good keyboard frame yields 15 output words, a mouse frame 11, one per
//  cycle while out_ready is high; the emitter sets the sustained frame rate
//  in_ready drops only on the sum check byte while the job queue is full
//  rst_n clears the parser phase, queue pointers and emitter state at once
//  out_valid holds with a stable word until out_ready takes it
//
// ----------------------------------------------------------------------------
module key_mouse_command_frame_parser_core #(
    parameter int unsigned MAX_PAYLOAD = kmcfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] destination,
    output logic [7:0] out_byte,
    output logic       packet_end,
    output logic       run_last
);

    // parser to queue
    logic                     push;
    kmcfp_pkg::job_t          push_job;
    // queue to emitter
    logic                     pop;
    kmcfp_pkg::job_t          head_job;
    kmcfp_pkg::queue_status_t q_status;

    // front: header hunt, field capture, sum check
    kmcfp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    // decoupling queue of complete frames
    kmcfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // back: report and acknowledgement word sequencer
    kmcfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .destination (destination),
        .out_byte    (out_byte),
        .packet_end  (packet_end),
        .run_last    (run_last)
    );

endmodule

// File: verif/tb_key_mouse_command_frame_parser_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_mouse_command_frame_parser_core
// self-checking bench for the key/mouse command frame parser
//
// feeds directed frames, a long receiver hold-off and a random mix of good,
// damaged and stray byte streams; an internal model of the parser predicts
// every keyboard, mouse and acknowledgement word, and a scoreboard compares
// the words leaving the block in order, field by field
// ----------------------------------------------------------------------------
module tb_key_mouse_command_frame_parser_core;

    import kmcfp_pkg::*;

    localparam int unsigned DEPTH        = MAX_PAYLOAD_DEF;  // payload store depth
    localparam int unsigned RANDOM_BYTES = 170;              // size of the random part
    localparam int unsigned STALL_LIMIT  = 5000;             // cycles with no handshake
    localparam int unsigned HOLD_CYCLES  = 400;              // long receiver hold-off
    localparam int unsigned DRAIN_CYCLES = 40;               // settle time at the end
    localparam int unsigned REPORT_MAX   = 10;               // mismatches shown in full

    // one output word as the block presents it
    typedef struct {
        logic [1:0] dest;
        logic [7:0] data;
        logic       pkt_end;
        logic       run_end;
    } report_word_t;

    // ------------------------------------------------------------------------
    // frame scoreboard: tracks the parser state and holds the expected words
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        phase_t       phase;
        logic [7:0]   frm_addr;
        logic [7:0]   frm_cmd;
        logic [7:0]   frm_len;
        logic [7:0]   data_seen;
        logic [7:0]   chk_acc;
        logic [7:0]   data_mem [DEPTH];
        report_word_t burst [$];
        report_word_t expected_words [$];
        int unsigned  errors;

        function new();
            phase     = PH_HUNT1;
            frm_addr  = '0;
            frm_cmd   = '0;
            frm_len   = '0;
            data_seen = '0;
            chk_acc   = '0;
            errors    = 0;
            foreach (data_mem[i]) data_mem[i] = '0;
        endfunction

        // payload byte as the reports see it: zero past the length or the store
        function logic [7:0] stored(input int idx);
            if (idx < DEPTH && idx < frm_len)
                return data_mem[idx];
            return 8'h00;
        endfunction

        function void emit(input logic [1:0] dest, input logic [7:0] data,
                           input logic pkt_end);
            report_word_t w;
            w.dest    = dest;
            w.data    = data;
            w.pkt_end = pkt_end;
            w.run_end = 1'b0;
            burst.push_back(w);
        endfunction

        function void emit_ack();
            logic [7:0] ack [7];
            logic [7:0] sum;
            ack[0] = HDR1;
            ack[1] = HDR2;
            ack[2] = frm_addr;
            ack[3] = frm_cmd;
            ack[4] = ACK_LEN;
            ack[5] = ACK_STATUS;
            sum = 8'h00;
            for (int i = 0; i < 6; i++) sum += ack[i];
            ack[6] = sum;
            for (int i = 0; i < 7; i++) emit(DEST_ACK, ack[i], i == 6);
        endfunction

        // one received byte accepted by the block
        function void note_rx(input logic [7:0] b);
            burst.delete();
            case (phase)
                PH_HUNT1:
                begin
                    if (b == HDR1) phase = PH_HUNT2;
                end
                PH_HUNT2:
                begin
                    if (b == HDR2)
                    begin
                        phase     = PH_ADDR;
                        foreach (data_mem[i]) data_mem[i] = '0;
                        data_seen = '0;
                        frm_len   = '0;
                        chk_acc   = HDR_SUM;
                    end
                    else
                    begin
                        phase = PH_HUNT1;
                    end
                end
                PH_ADDR:
                begin
                    frm_addr = b;
                    chk_acc += b;
                    phase    = PH_CMD;
                end
                PH_CMD:
                begin
                    frm_cmd  = b;
                    chk_acc += b;
                    phase    = PH_LEN;
                end
                PH_LEN:
                begin
                    frm_len   = b;
                    chk_acc  += b;
                    data_seen = '0;
                    if (b > DEPTH)
                        phase = PH_HUNT1;
                    else if (b == 8'h00)
                        phase = PH_SUM;
                    else
                        phase = PH_DATA;
                end
                PH_DATA:
                begin
                    if (data_seen < DEPTH) data_mem[data_seen] = b;
                    chk_acc  += b;
                    data_seen = data_seen + 8'd1;
                    if (data_seen >= frm_len) phase = PH_SUM;
                end
                PH_SUM:
                begin
                    phase = PH_HUNT1;
                    if (b == chk_acc)
                    begin
                        if (frm_cmd == CMD_KEYBOARD)
                        begin
                            emit(DEST_KEYBOARD, stored(0), 1'b0);
                            emit(DEST_KEYBOARD, 8'h00, 1'b0);
                            for (int i = 2; i < 8; i++)
                                emit(DEST_KEYBOARD, stored(i), i == 7);
                            emit_ack();
                        end
                        else if (frm_cmd == CMD_MOUSE)
                        begin
                            for (int i = 1; i <= 4; i++)
                                emit(DEST_MOUSE, stored(i), i == 4);
                            emit_ack();
                        end
                    end
                end
                default:
                begin
                    phase = PH_HUNT1;
                end
            endcase
            if (burst.size() > 0) burst[burst.size() - 1].run_end = 1'b1;
            foreach (burst[i]) expected_words.push_back(burst[i]);
        endfunction

        // one output word accepted from the block
        function void check_word(input logic [1:0] dest, input logic [7:0] data,
                                 input logic pkt_end, input logic run_end);
            report_word_t w;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("ERROR: unexpected word dest=%0d data=%02h end=%0b last=%0b",
                             dest, data, pkt_end, run_end);
                return;
            end
            w = expected_words.pop_front();
            if (w.dest !== dest || w.data !== data || w.pkt_end !== pkt_end
                || w.run_end !== run_end)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("ERROR: exp %0d/%02h/%0b/%0b got %0d/%02h/%0b/%0b",
                             w.dest, w.data, w.pkt_end, w.run_end,
                             dest, data, pkt_end, run_end);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block
    // ------------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] destination;
    logic [7:0] out_byte;
    logic       packet_end;
    logic       run_last;

    frame_scoreboard board = new();

    bit          send_gaps    = 1'b1;   // sender idles at random when set
    bit          recv_gaps    = 1'b1;   // receiver stalls at random when set
    bit          hold_go      = 1'b0;   // asks the receiver for the long hold-off
    int unsigned hold_left    = 0;
    int unsigned stall_cycles = 0;
    int unsigned rx_sent      = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    key_mouse_command_frame_parser_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .destination (destination),
        .out_byte    (out_byte),
        .packet_end  (packet_end),
        .run_last    (run_last)
    );

    // ------------------------------------------------------------------------
    // monitor: both handshakes are sampled at the same edge in one process,
    // so a word can never be checked before the byte that caused it is noted
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            board.note_rx(rx_byte);
        if (out_valid && out_ready)
            board.check_word(destination, out_byte, packet_end, run_last);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
    end

    // watchdog: too long without any word moving on either side
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request so the job
    // queue fills and the parser has to refuse the sum check byte
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !recv_gaps || ($urandom_range(0, 99) >= 18);
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // offer one byte and wait for it to be taken; valid stays high afterwards
    // so back-to-back words need no second assignment in the same step
    task automatic push_rx(input logic [7:0] value);
        while (send_gaps && $urandom_range(0, 99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        rx_sent++;
    endtask

    // whole frame; a length over the store depth stops after the length byte,
    // as the parser drops the frame there
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                              input logic [7:0] len, input logic [63:0] data,
                              input bit corrupt);
        logic [7:0] chk;
        chk = HDR1 + HDR2 + addr + cmd + len;
        push_rx(HDR1);
        push_rx(HDR2);
        push_rx(addr);
        push_rx(cmd);
        push_rx(len);
        if (len > DEPTH) return;
        for (int n = 0; n < len; n++)
        begin
            chk += data[8*n +: 8];
            push_rx(data[8*n +: 8]);
        end
        if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
        push_rx(chk);
    endtask

    function automatic logic [63:0] rand_data();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] report_cmd();
        return $urandom_range(0, 1) ? CMD_KEYBOARD : CMD_MOUSE;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned random_start;
        int unsigned frame_idx;
        int unsigned pick;
        logic [7:0]  cmd;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray bytes outside any frame
        push_rx(8'h00);
        push_rx(8'hFF);
        push_rx(HDR2);
        // extremes of address and payload, both report kinds
        send_frame(8'h00, CMD_KEYBOARD, 8'd8, {8{8'hFF}}, 1'b0);
        send_frame(8'hFF, CMD_KEYBOARD, 8'd0, '0, 1'b0);
        send_frame(8'hFF, CMD_MOUSE, 8'd4, '0, 1'b0);
        send_frame(8'h5A, CMD_MOUSE, 8'd1, 64'h0102030405060708, 1'b0);
        send_frame(8'hA5, CMD_MOUSE, 8'd8, {8{8'hFF}}, 1'b0);
        // zero fill of payload bytes past the length
        send_frame(8'h33, CMD_KEYBOARD, 8'd3, 64'h8877665544332211, 1'b0);
        // repeated first header byte in second position is dropped, then the
        // second header byte alone is ignored while hunting
        push_rx(HDR1);
        push_rx(HDR1);
        push_rx(HDR2);
        push_rx(HDR1);
        push_rx(8'h00);
        send_frame(8'h01, CMD_KEYBOARD, 8'd2, 64'h00000000000055AA, 1'b0);
        // length just past the store and the largest length
        send_frame(8'h10, CMD_KEYBOARD, 8'd9, '0, 1'b0);
        send_frame(8'h11, CMD_MOUSE, 8'd255, '0, 1'b0);
        // bad sum check, then unknown commands with a good sum check
        send_frame(8'h22, CMD_KEYBOARD, 8'd4, 64'h00000000DEADBEEF, 1'b1);
        send_frame(8'h44, ACK_LEN, 8'd1, 64'h7F, 1'b0);
        send_frame(8'h55, 8'hFF, 8'd0, '0, 1'b0);

        // long receiver hold-off while full keyboard frames keep coming
        hold_go   = 1'b1;
        send_gaps = 1'b0;
        repeat (6) send_frame(8'($urandom), CMD_KEYBOARD, 8'd8, rand_data(), 1'b0);
        send_gaps = 1'b1;

        // random part: mostly good frames with random content, some damage
        random_start = rx_sent;
        frame_idx    = 0;
        while (rx_sent - random_start < RANDOM_BYTES)
        begin
            // a stretch with no idling on either side
            send_gaps = !(frame_idx >= 4 && frame_idx < 12);
            recv_gaps = send_gaps;
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                send_frame(8'($urandom), report_cmd(), 8'($urandom_range(0, DEPTH)),
                           rand_data(), 1'b0);
            end
            else if (pick < 78)
            begin
                send_frame(8'($urandom), report_cmd(), 8'($urandom_range(0, DEPTH)),
                           rand_data(), 1'b1);
            end
            else if (pick < 84)
            begin
                do cmd = 8'($urandom); while (cmd == CMD_KEYBOARD || cmd == CMD_MOUSE);
                send_frame(8'($urandom), cmd, 8'($urandom_range(0, DEPTH)),
                           rand_data(), 1'b0);
            end
            else if (pick < 90)
            begin
                send_frame(8'($urandom), report_cmd(),
                           8'($urandom_range(DEPTH + 1, 255)), rand_data(), 1'b0);
            end
            else if (pick < 95)
            begin
                repeat ($urandom_range(1, 4)) push_rx(8'($urandom));
            end
            else
            begin
                push_rx(HDR1);
                push_rx(8'($urandom));
            end
            frame_idx++;
        end
        send_gaps = 1'b1;
        recv_gaps = 1'b1;

        in_valid <= 1'b0;
        while (board.expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.expected_words.size() != 0)
        begin
            board.errors++;
            $display("ERROR: %0d expected words never arrived",
                     board.expected_words.size());
        end
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
